FILE: hdl/rvn_pkg.sv
// -----------------------------------------------------------------------------
// rvn_pkg
// Shared widths, codes and handshake structs of the RMS vector normalizer.
// -----------------------------------------------------------------------------
`default_nettype none

package rvn_pkg;

  // Field widths
  localparam int ElemW     = 24;
  localparam int WeightW   = 16;
  localparam int LenW      = 13;
  localparam int InDataW   = ((ElemW + WeightW + 7) / 8) * 8;
  localparam int OutDataW  = ((ElemW + 7) / 8) * 8;

  // Vector length limits
  localparam int MaxLength   = 4096;
  localparam int CntW        = $clog2(MaxLength + 1);
  localparam int VecLenReset = 4096;

  // Accumulator and factor
  localparam int SumW      = 60;
  localparam int FactorW   = 32;
  localparam int FactorFrac = 22;
  localparam int WeightFrac = 14;
  localparam int EpsQ32    = 42950;

  // Serial multiplier: signed multiplicand, two's complement multiplier
  localparam int MulAW     = 35;
  localparam int MulBW     = FactorW + 1;
  localparam int ProdW     = MulAW + 1 + MulBW;

  // Serial divider and square root
  localparam int DivSteps  = 77;
  localparam int DivDvdW   = DivSteps;
  localparam int DivDvsW   = SumW + 1;
  localparam int QuoW      = 64;
  localparam int SqrtSteps = QuoW / 2;

  // Configuration port
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = LenW;
  localparam logic [CfgIdxW-1:0] RegVectorLength = 2'd0;
  localparam logic [CfgIdxW-1:0] RegApplyWeight  = 2'd1;

  // Item codes
  localparam logic CmdAccumulate  = 1'b0;
  localparam logic CmdScale       = 1'b1;
  localparam logic StatusOk       = 1'b0;
  localparam logic StatusNotReady = 1'b1;

  typedef struct packed {
    logic             start;
    logic [MulAW-1:0] mcand;
    logic [MulBW-1:0] mplier;
  } mul_req_t;

  typedef struct packed {
    logic             done;
    logic [ProdW-1:0] product;
  } mul_rsp_t;

  typedef struct packed {
    logic            start;
    logic [SumW-1:0] sum;
    logic [CntW-1:0] len;
  } fac_req_t;

  typedef struct packed {
    logic               done;
    logic [FactorW-1:0] factor;
  } fac_rsp_t;

endpackage

`default_nettype wire

FILE: hdl/rms_vector_normalizer_core.sv
// -----------------------------------------------------------------------------
// rms_vector_normalizer_core
// Two-pass RMS normalization in fixed point: accumulate squares, form the
// inverse RMS factor, then scale elements by factor and weight when weighting is on.
//
//   channel | direction | tdata (low bit up)             | tuser
//   s_axis  | in        | element_value, norm_weight     | command
//   m_axis  | out       | normalized_value               | status
//   cfg     | in        | write enable, index, data      | -
//
// Accumulate item: one bit-serial multiply (33 steps) squares the element.
// Last item of a vector: the factor unit then runs
//   (two 77-step serial divisions and a 32-step square root).
// Scale item: two serial multiplies when weighted, none otherwise.
// One item at a time; a finished result waits in the output register.
// Reset clears the control state and the accumulator at once; no clearing pass.
// -----------------------------------------------------------------------------
`default_nettype none

module rms_vector_normalizer_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rvn_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rvn_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [rvn_pkg::InDataW-1:0]  s_axis_tdata_i,  // element_value, norm_weight
  input  logic                         s_axis_tuser_i,  // command
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [rvn_pkg::OutDataW-1:0] m_axis_tdata_o,  // normalized_value
  output logic                         m_axis_tuser_o   // status
);
  import rvn_pkg::*;

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StSquare = 3'd1;
  localparam logic [2:0] StFactor = 3'd2;
  localparam logic [2:0] StScaleX = 3'd3;
  localparam logic [2:0] StScaleW = 3'd4;
  localparam logic [2:0] StResult = 3'd5;

  localparam logic [ProdW-1:0] RndX = ProdW'(1) << (FactorFrac - 1);
  localparam logic [ProdW-1:0] RndW = ProdW'(1) << (WeightFrac - 1);
  localparam int YW = ProdW - WeightFrac;

  logic [2:0]         state_q, state_d;
  logic [LenW-1:0]    vec_len_q;
  logic               apply_w_q;
  logic [SumW-1:0]    sum_q, sum_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [FactorW-1:0] inv_q, inv_d;
  logic               ready_q, ready_d;
  logic [WeightW-1:0] w_q;
  logic [ElemW-1:0]   res_val_q, res_val_d;
  logic               res_st_q, res_st_d;
  logic               out_val_q;
  logic [ElemW-1:0]   out_data_q;
  logic               out_user_q;

  logic               in_acc, out_free;
  logic [ElemW-1:0]   elem;
  logic [WeightW-1:0] wgt;
  logic [CntW-1:0]    len_eff, count_new;
  logic [SumW-1:0]    base_sum;
  logic [SumW:0]      sum_add;
  logic [ProdW-1:0]   t_sum, y_sum;
  logic [MulAW-1:0]   t_val;
  logic [YW-1:0]      y_wide;
  logic [ElemW-1:0]   y_sat;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  fac_req_t fac_req;
  fac_rsp_t fac_rsp;

  rvn_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  rvn_factor u_factor (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (fac_req),
    .rsp_o  (fac_rsp)
  );

  assign s_axis_tready_o = (state_q == StIdle);
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_val_q || m_axis_tready_i;
  assign elem     = s_axis_tdata_i[ElemW-1:0];
  assign wgt      = s_axis_tdata_i[ElemW +: WeightW];

  always_comb begin
    if (vec_len_q == '0) begin
      len_eff = CntW'(1);
    end else if (32'(vec_len_q) > MaxLength) begin
      len_eff = CntW'(MaxLength);
    end else begin
      len_eff = CntW'(vec_len_q);
    end
  end

  always_comb begin
    base_sum  = ready_q ? '0 : sum_q;
    count_new = (ready_q ? '0 : count_q) + 1'b1;
    sum_add   = {1'b0, base_sum} + (SumW + 1)'(mul_rsp.product[2*ElemW-1:0]);
    t_sum     = mul_rsp.product + RndX;
    t_val     = t_sum[FactorFrac +: MulAW];
    y_sum     = mul_rsp.product + RndW;
    y_wide    = y_sum[ProdW-1:WeightFrac];
    if ((y_wide[YW-1:ElemW-1] == '0) || (y_wide[YW-1:ElemW-1] == '1)) begin
      y_sat = y_wide[ElemW-1:0];
    end else if (y_wide[YW-1]) begin
      y_sat = {1'b1, {(ElemW-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(ElemW-1){1'b1}}};
    end
  end

  always_comb begin
    state_d   = state_q;
    sum_d     = sum_q;
    count_d   = count_q;
    inv_d     = inv_q;
    ready_d   = ready_q;
    res_val_d = res_val_q;
    res_st_d  = res_st_q;
    mul_req.start  = 1'b0;
    mul_req.mcand  = {{(MulAW-ElemW){elem[ElemW-1]}}, elem};
    mul_req.mplier = {{(MulBW-ElemW){elem[ElemW-1]}}, elem};
    fac_req.start  = 1'b0;
    fac_req.sum    = sum_add[SumW] ? '1 : sum_add[SumW-1:0];
    fac_req.len    = len_eff;

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (s_axis_tuser_i == CmdAccumulate) begin
            mul_req.start = 1'b1;
            state_d       = StSquare;
          end else if (!apply_w_q) begin
            res_val_d = elem;
            res_st_d  = StatusOk;
            state_d   = StResult;
          end else if (!ready_q) begin
            res_val_d = '0;
            res_st_d  = StatusNotReady;
            state_d   = StResult;
          end else begin
            mul_req.start  = 1'b1;
            mul_req.mplier = {1'b0, inv_q};
            state_d        = StScaleX;
          end
        end
      end
      StSquare: begin
        if (mul_rsp.done) begin
          sum_d   = fac_req.sum;
          count_d = count_new;
          ready_d = 1'b0;
          if (count_new >= len_eff) begin
            fac_req.start = 1'b1;
            state_d       = StFactor;
          end else begin
            state_d = StIdle;
          end
        end
      end
      StFactor: begin
        if (fac_rsp.done) begin
          inv_d   = fac_rsp.factor;
          ready_d = 1'b1;
          state_d = StIdle;
        end
      end
      StScaleX: begin
        if (mul_rsp.done) begin
          mul_req.start  = 1'b1;
          mul_req.mcand  = t_val;
          mul_req.mplier = {{(MulBW-WeightW){w_q[WeightW-1]}}, w_q};
          state_d        = StScaleW;
        end
      end
      StScaleW: begin
        if (mul_rsp.done) begin
          res_val_d = y_sat;
          res_st_d  = StatusOk;
          state_d   = StResult;
        end
      end
      StResult: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      vec_len_q <= LenW'(VecLenReset);
      apply_w_q <= 1'b1;
      sum_q     <= '0;
      count_q   <= '0;
      inv_q     <= '0;
      ready_q   <= 1'b0;
      out_val_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sum_q   <= sum_d;
      count_q <= count_d;
      inv_q   <= inv_d;
      ready_q <= ready_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegVectorLength: vec_len_q <= cfg_data_i[LenW-1:0];
          RegApplyWeight:  apply_w_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (state_q == StResult && out_free) begin
        out_val_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_val_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_val_q <= res_val_d;
    res_st_q  <= res_st_d;
    if (in_acc) begin
      w_q <= wgt;
    end
    if (state_q == StResult && out_free) begin
      out_data_q <= res_val_q;
      out_user_q <= res_st_q;
    end
  end

  assign m_axis_tvalid_o = out_val_q;
  assign m_axis_tdata_o  = OutDataW'(out_data_q);
  assign m_axis_tuser_o  = out_user_q;

  a_fac_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fac_rsp.done |-> state_q == StFactor)
    else $error("factor done outside factor state");

  a_mul_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp.done |-> (state_q == StSquare || state_q == StScaleX || state_q == StScaleW))
    else $error("multiplier done with no multiply pending");

  a_ready_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_q |-> count_q != '0)
    else $error("factor ready with empty vector");

  a_not_ready_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == StatusNotReady) |-> m_axis_tdata_o == '0)
    else $error("not-ready result carries a value");

  a_acc_to_square: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser_i == CmdAccumulate) |=> state_q == StSquare)
    else $error("accumulate item did not start squaring");

endmodule

`default_nettype wire

FILE: hdl/rvn_mul.sv
// -----------------------------------------------------------------------------
// rvn_mul
// Bit-serial signed multiplier: one multiplier bit per cycle, right-shifting
// product register, sign step of the multiplier subtracts.
// -----------------------------------------------------------------------------
`default_nettype none

module rvn_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rvn_pkg::mul_req_t req_i,
  output rvn_pkg::mul_rsp_t rsp_o
);
  import rvn_pkg::*;

  localparam int CntBits = $clog2(MulBW);
  localparam logic [CntBits-1:0] LastStep = CntBits'(MulBW - 1);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic [MulAW-1:0]   mc_q;
  logic [MulAW:0]     hi_q, hi_d;
  logic [MulBW-1:0]   lo_q, lo_d;
  logic [MulAW+1:0]   mc_ext, hi_ext, step_sum;

  always_comb begin
    mc_ext = {{2{mc_q[MulAW-1]}}, mc_q};
    hi_ext = {hi_q[MulAW], hi_q};
    if (!lo_q[0]) begin
      step_sum = hi_ext;
    end else if (cnt_q == LastStep) begin
      step_sum = hi_ext - mc_ext;
    end else begin
      step_sum = hi_ext + mc_ext;
    end
    hi_d   = step_sum[MulAW+1:1];
    lo_d   = {step_sum[0], lo_q[MulBW-1:1]};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mc_q <= req_i.mcand;
      hi_q <= '0;
      lo_q <= req_i.mplier;
    end else if (busy_q) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.product = {hi_q, lo_q};

endmodule

`default_nettype wire

FILE: hdl/rvn_factor.sv
// -----------------------------------------------------------------------------
// rvn_factor
// Inverse RMS factor: serial mean division, serial reciprocal division of
// 2^76 by (mean + eps), then a serial integer square root, one bit a cycle.
// -----------------------------------------------------------------------------
`default_nettype none

module rvn_factor (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rvn_pkg::fac_req_t req_i,
  output rvn_pkg::fac_rsp_t rsp_o
);
  import rvn_pkg::*;

  localparam int CntBits = $clog2(DivSteps);
  localparam logic [1:0] FIdle = 2'd0;
  localparam logic [1:0] FDiv  = 2'd1;
  localparam logic [1:0] FSqrt = 2'd2;
  localparam logic [DivDvdW-1:0] RecipDvd = DivDvdW'(1) << (DivSteps - 1);

  logic [1:0]         state_q, state_d;
  logic               recip_q, recip_d;
  logic               done_q, done_d;
  logic [CntBits-1:0] cnt_q, cnt_d;

  logic [DivDvdW-1:0] dvd_q, dvd_d;
  logic [DivDvsW-1:0] dvs_q, dvs_d;
  logic [DivDvsW-1:0] rem_q, rem_d;
  logic [QuoW-1:0]    quo_q, quo_d;
  logic [QuoW-1:0]    rad_q, rad_d;
  logic [FactorW-1:0] root_q, root_d;
  logic [FactorW+1:0] srem_q, srem_d;

  logic [DivDvsW:0]   rem_sh, rem_sub;
  logic               div_ge;
  logic [FactorW+3:0] sq_try, sq_sub;
  logic               sq_ge;

  always_comb begin
    rem_sh  = {rem_q, dvd_q[DivDvdW-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    div_ge  = rem_sh >= {1'b0, dvs_q};
    sq_try  = {srem_q, rad_q[QuoW-1:QuoW-2]};
    sq_sub  = sq_try - {2'b00, root_q, 2'b01};
    sq_ge   = sq_try >= {2'b00, root_q, 2'b01};

    state_d = state_q;
    recip_d = recip_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    dvd_d   = dvd_q;
    dvs_d   = dvs_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    rad_d   = rad_q;
    root_d  = root_q;
    srem_d  = srem_q;

    case (state_q)
      FIdle: begin
        if (req_i.start) begin
          state_d = FDiv;
          recip_d = 1'b0;
          cnt_d   = '0;
          dvd_d   = DivDvdW'(req_i.sum);
          dvs_d   = DivDvsW'(req_i.len);
          rem_d   = '0;
          quo_d   = '0;
        end
      end
      FDiv: begin
        rem_d = div_ge ? rem_sub[DivDvsW-1:0] : rem_sh[DivDvsW-1:0];
        quo_d = {quo_q[QuoW-2:0], div_ge};
        dvd_d = dvd_q << 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntBits'(DivSteps - 1)) begin
          cnt_d = '0;
          if (!recip_q) begin
            recip_d = 1'b1;
            dvd_d   = RecipDvd;
            dvs_d   = quo_d[DivDvsW-1:0] + DivDvsW'(EpsQ32);
            rem_d   = '0;
            quo_d   = '0;
          end else begin
            state_d = FSqrt;
            rad_d   = quo_d;
            root_d  = '0;
            srem_d  = '0;
          end
        end
      end
      FSqrt: begin
        srem_d = sq_ge ? sq_sub[FactorW+1:0] : sq_try[FactorW+1:0];
        root_d = {root_q[FactorW-2:0], sq_ge};
        rad_d  = rad_q << 2;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == CntBits'(SqrtSteps - 1)) begin
          state_d = FIdle;
          done_d  = 1'b1;
        end
      end
      default: state_d = FIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FIdle;
      recip_q <= 1'b0;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      recip_q <= recip_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    dvs_q  <= dvs_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    rad_q  <= rad_d;
    root_q <= root_d;
    srem_q <= srem_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.factor = root_q;

endmodule

`default_nettype wire
